@@ rtl/core/solar_ra_dec_low_precision_assert.svh @@
// Assertion macros shared by the solar position core
`ifndef SOLAR_RA_DEC_LOW_PRECISION_ASSERT_SVH
`define SOLAR_RA_DEC_LOW_PRECISION_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SRD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/srd_pkg.sv @@
package srd_pkg;

	localparam int XW = 34;
	localparam int SQ_STEPS = 31;
	localparam int SQ_W = 62;
	localparam logic [31:0] J2000_UNIX = 32'd946728000;
	localparam logic signed [XW-1:0] KINV = 34'sd652032874;
	localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
	localparam logic [SQ_W-1:0] ONE_Q60 = 62'h1000_0000_0000_0000;

	function automatic logic [63:0] frac64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] r;
		logic [63:0] q;
		r = num;
		q = '0;
		for (int i = 0; i < 64; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] div64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			q = q << 1;
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] atan_turn64(input int unsigned i);
		logic [63:0] acc;
		logic [63:0] term;
		logic [127:0] prod;
		int unsigned k;
		int unsigned p;
		acc = '0;
		k = 0;
		p = i;
		if (i == 0)
			return 64'h2000_0000_0000_0000;
		while (p <= 63) begin
			term = div64(64'd1 << (64 - p), 64'(2 * k + 1));
			if (k[0])
				acc = acc - term;
			else
				acc = acc + term;
			k = k + 1;
			p = i * (2 * k + 1);
		end
		prod = {64'd0, acc} * {64'd0, INV_TWO_PI_Q64};
		return prod[127:64];
	endfunction

	localparam logic [63:0] M_BASE = frac64(64'd993133, 64'd1000000);
	localparam logic [63:0] M_RATE = frac64(64'd99997361, 64'd3155760000000000);
	localparam logic [63:0] L_BASE = frac64(64'd7859453, 64'd10000000);
	localparam logic [63:0] L_RATE = frac64(64'd61912, 64'd40898649600000000);
	localparam logic [63:0] K_DL1_64 = frac64(64'd6893, 64'd1296000);
	localparam logic [63:0] K_DL2_64 = frac64(64'd72, 64'd1296000);
	localparam logic [31:0] K_DL1 = K_DL1_64[63:32];
	localparam logic [31:0] K_DL2 = K_DL2_64[63:32];
	localparam logic [63:0] COSE_64 = frac64(64'd91748, 64'd100000);
	localparam logic [63:0] SINE_64 = frac64(64'd39778, 64'd100000);
	localparam logic [29:0] COSE = COSE_64[63:34];
	localparam logic [29:0] SINE = SINE_64[63:34];

endpackage

@@ rtl/core/srd_cordic.sv @@
module srd_cordic #(
	parameter int STEPS = 24,
	parameter int AW = 32,
	parameter int SW = 1,
	parameter bit VECTORING = 1'b0
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic signed [srd_pkg::XW-1:0] in_x,
	input logic signed [srd_pkg::XW-1:0] in_y,
	input logic signed [AW:0] in_z,
	input logic [SW-1:0] in_side,
	output logic out_valid,
	output logic signed [srd_pkg::XW-1:0] out_x,
	output logic signed [srd_pkg::XW-1:0] out_y,
	output logic signed [AW:0] out_z,
	output logic [SW-1:0] out_side
);
	import srd_pkg::*;

	logic vld_s [STEPS];
	logic signed [XW-1:0] x_s [STEPS];
	logic signed [XW-1:0] y_s [STEPS];
	logic signed [AW:0] z_s [STEPS];
	logic [SW-1:0] side_s [STEPS];

	logic vp [STEPS];
	logic signed [XW-1:0] xp [STEPS];
	logic signed [XW-1:0] yp [STEPS];
	logic signed [AW:0] zp [STEPS];
	logic [SW-1:0] sp [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic [63:0] TURN64 = atan_turn64(i);
		localparam logic [63:0] TAB64 = TURN64 >> (64 - AW);
		localparam logic signed [AW:0] TAB = $signed(TAB64[AW:0]);
		logic signed [XW-1:0] xs;
		logic signed [XW-1:0] ys;
		logic go_pos;

		if (i == 0) begin : g_first
			assign vp[i] = in_valid;
			assign xp[i] = in_x;
			assign yp[i] = in_y;
			assign zp[i] = in_z;
			assign sp[i] = in_side;
		end else begin : g_next
			assign vp[i] = vld_s[i-1];
			assign xp[i] = x_s[i-1];
			assign yp[i] = y_s[i-1];
			assign zp[i] = z_s[i-1];
			assign sp[i] = side_s[i-1];
		end

		always_comb begin
			xs = xp[i] >>> i;
			ys = yp[i] >>> i;
			go_pos = VECTORING ? !yp[i][XW-1] : !zp[i][AW];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i] <= 1'b0;
			else if (en)
				vld_s[i] <= vp[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i] <= sp[i];
				if (go_pos != VECTORING) begin
					x_s[i] <= xp[i] - ys;
					y_s[i] <= yp[i] + xs;
					z_s[i] <= zp[i] - TAB;
				end else begin
					x_s[i] <= xp[i] + ys;
					y_s[i] <= yp[i] - xs;
					z_s[i] <= zp[i] + TAB;
				end
			end
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign out_x = x_s[STEPS-1];
	assign out_y = y_s[STEPS-1];
	assign out_z = z_s[STEPS-1];
	assign out_side = side_s[STEPS-1];

endmodule

@@ rtl/core/solar_ra_dec_low_precision.sv @@
// channel  | valid      | ready      | word
// ---------+------------+------------+-------------------------------
// time     | time_valid | time_ready | unix_time
// pos      | pos_valid  | pos_ready  | right_ascension, declination
//
// One word per cycle. The pipeline runs, in order, the M and 2M
// rotation CORDIC passes side by side, then the L rotation pass, the isqrt
// chain and the vectoring passes for DEC and RA side by side.
// The whole pipeline advances together; it holds while pos_valid is high
// and pos_ready low, so no word is dropped or repeated.
// Reset clears the valid bits only; the data registers are not reset.
`include "solar_ra_dec_low_precision_assert.svh"

module solar_ra_dec_low_precision #(
	parameter int CORDIC_STEPS = 24,
	parameter int ANGLE_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic time_valid,
	output logic time_ready,
	input logic [31:0] unix_time,
	output logic pos_valid,
	input logic pos_ready,
	output logic [20:0] right_ascension,
	output logic signed [21:0] declination
);
	import srd_pkg::*;

	localparam int AW = ANGLE_BITS;
	localparam int SWA = 65 + AW;

	logic en;
	assign en = !pos_valid || pos_ready;
	assign time_ready = en;

	// time offset and phase products
	logic signed [33:0] us_c;
	logic signed [66:0] pml_c, pmh_c, pll_c, plh_c;
	logic v_s1;
	logic [63:0] mlo_s1, llo_s1;
	logic [31:0] mhi_s1, lhi_s1;

	always_comb begin
		us_c = $signed({2'b00, unix_time}) - $signed({2'b00, J2000_UNIX});
		pml_c = us_c * $signed({1'b0, M_RATE[31:0]});
		pmh_c = us_c * $signed({1'b0, M_RATE[63:32]});
		pll_c = us_c * $signed({1'b0, L_RATE[31:0]});
		plh_c = us_c * $signed({1'b0, L_RATE[63:32]});
	end

	// phase sums
	logic v_s2;
	logic [AW-1:0] ma_s2;
	logic [63:0] lin_s2;
	logic [63:0] m64_c, lin_c;

	always_comb begin
		m64_c = M_BASE + mlo_s1 + {mhi_s1, 32'd0};
		lin_c = L_BASE + llo_s1 + {lhi_s1, 32'd0};
	end

	// fold into +-1/4 turn
	logic [AW-1:0] ang2_c;
	logic flip_m_c, flip_2m_c;
	logic [AW-1:0] fm_c, f2m_c;

	always_comb begin
		ang2_c = {ma_s2[AW-2:0], 1'b0};
		flip_m_c = ma_s2[AW-1] ^ ma_s2[AW-2];
		flip_2m_c = ang2_c[AW-1] ^ ang2_c[AW-2];
		fm_c = {ma_s2[AW-1] ^ flip_m_c, ma_s2[AW-2:0]};
		f2m_c = {ang2_c[AW-1] ^ flip_2m_c, ang2_c[AW-2:0]};
	end

	logic va_c, vb_c;
	logic signed [XW-1:0] xa_c, ya_c, za_x_c, yb_c;
	logic signed [AW:0] za_c, zb_c;
	logic [SWA-1:0] sda_c;
	logic [0:0] sdb_c;

	srd_cordic #(.STEPS(CORDIC_STEPS), .AW(AW), .SW(SWA), .VECTORING(1'b0)) u_rot_m (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.in_x(KINV), .in_y('0), .in_z({fm_c[AW-1], fm_c}),
		.in_side({flip_m_c, lin_s2, ma_s2}),
		.out_valid(va_c), .out_x(xa_c), .out_y(ya_c), .out_z(za_c), .out_side(sda_c)
	);

	srd_cordic #(.STEPS(CORDIC_STEPS), .AW(AW), .SW(1), .VECTORING(1'b0)) u_rot_2m (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.in_x(KINV), .in_y('0), .in_z({f2m_c[AW-1], f2m_c}),
		.in_side(flip_2m_c),
		.out_valid(vb_c), .out_x(za_x_c), .out_y(yb_c), .out_z(zb_c), .out_side(sdb_c)
	);

	// sines of M and 2M
	logic v_s4;
	logic signed [XW-1:0] sm_s4, s2m_s4;
	logic [63:0] lin_s4;
	logic [AW-1:0] ma_s4;

	// equation of center products
	logic v_s5;
	logic signed [66:0] k1_c, k2_c;
	logic signed [63:0] k1_s5, k2_s5;
	logic [63:0] lin_s5;
	logic [AW-1:0] ma_s5;

	always_comb begin
		k1_c = $signed({1'b0, K_DL1}) * sm_s4;
		k2_c = $signed({1'b0, K_DL2}) * s2m_s4;
	end

	// longitude
	logic v_s6;
	logic [AW-1:0] la_s6;
	logic [63:0] l64_c;
	logic flip_l_c;
	logic [AW-1:0] fl_c;

	always_comb begin
		l64_c = {ma_s5, {(64 - AW){1'b0}}} + lin_s5 + {k1_s5[61:0], 2'b00}
			+ {k2_s5[61:0], 2'b00};
		flip_l_c = la_s6[AW-1] ^ la_s6[AW-2];
		fl_c = {la_s6[AW-1] ^ flip_l_c, la_s6[AW-2:0]};
	end

	logic vc_c;
	logic signed [XW-1:0] xc_c, yc_c;
	logic signed [AW:0] zc_c;
	logic [0:0] sdc_c;

	srd_cordic #(.STEPS(CORDIC_STEPS), .AW(AW), .SW(1), .VECTORING(1'b0)) u_rot_l (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s6),
		.in_x(KINV), .in_y('0), .in_z({fl_c[AW-1], fl_c}),
		.in_side(flip_l_c),
		.out_valid(vc_c), .out_x(xc_c), .out_y(yc_c), .out_z(zc_c), .out_side(sdc_c)
	);

	// cos L, sin L
	logic v_s7;
	logic signed [XW-1:0] cl_s7, sl_s7;

	// obliquity rotation
	logic v_s8;
	logic signed [64:0] yv_c, zv_c;
	logic signed [XW-1:0] yv_s8, zv_s8, cl_s8;

	always_comb begin
		yv_c = ($signed({1'b0, COSE}) * sl_s7) >>> 30;
		zv_c = ($signed({1'b0, SINE}) * sl_s7) >>> 30;
	end

	// Z squared
	logic v_s9;
	logic signed [67:0] zz_c;
	logic [SQ_W-1:0] zz_s9;
	logic signed [XW-1:0] yv_s9, zv_s9, cl_s9;

	assign zz_c = zv_s8 * zv_s8;

	// 1 - Z^2
	logic v_s10;
	logic [SQ_W-1:0] rem_s10;
	logic signed [XW-1:0] yv_s10, zv_s10, cl_s10;

	// isqrt, one result bit per stage
	logic sq_vld_s [SQ_STEPS];
	logic [SQ_W-1:0] sq_v_s [SQ_STEPS];
	logic [SQ_W-1:0] sq_r_s [SQ_STEPS];
	logic signed [XW-1:0] sq_yv_s [SQ_STEPS];
	logic signed [XW-1:0] sq_zv_s [SQ_STEPS];
	logic signed [XW-1:0] sq_cl_s [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (60 - 2 * k);
		logic pv;
		logic [SQ_W-1:0] pvv, pr, sum;
		logic signed [XW-1:0] pyv, pzv, pcl;

		if (k == 0) begin : g_first
			assign pv = v_s10;
			assign pvv = rem_s10;
			assign pr = '0;
			assign pyv = yv_s10;
			assign pzv = zv_s10;
			assign pcl = cl_s10;
		end else begin : g_next
			assign pv = sq_vld_s[k-1];
			assign pvv = sq_v_s[k-1];
			assign pr = sq_r_s[k-1];
			assign pyv = sq_yv_s[k-1];
			assign pzv = sq_zv_s[k-1];
			assign pcl = sq_cl_s[k-1];
		end

		assign sum = pr + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_vld_s[k] <= 1'b0;
			else if (en)
				sq_vld_s[k] <= pv;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_yv_s[k] <= pyv;
				sq_zv_s[k] <= pzv;
				sq_cl_s[k] <= pcl;
				if (pvv >= sum) begin
					sq_v_s[k] <= pvv - sum;
					sq_r_s[k] <= (pr >> 1) + BIT;
				end else begin
					sq_v_s[k] <= pvv;
					sq_r_s[k] <= pr >> 1;
				end
			end
		end
	end

	// atan2 operands
	logic v_s11;
	logic signed [XW-1:0] dx_s11, dy_s11, rx_s11, ry_s11;
	logic [1:0] dsd_s11, rsd_s11;
	logic signed [XW-1:0] rho_c, xr_c;

	always_comb begin
		rho_c = $signed({3'b000, sq_r_s[SQ_STEPS-1][30:0]});
		xr_c = sq_cl_s[SQ_STEPS-1] + rho_c;
	end

	logic vd_c, ve_c;
	logic signed [XW-1:0] xd_c, yd_c, xe_c, ye_c;
	logic signed [AW:0] zd_c, ze_c;
	logic [1:0] sdd_c, sde_c;

	srd_cordic #(.STEPS(CORDIC_STEPS), .AW(AW), .SW(2), .VECTORING(1'b1)) u_vec_dec (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s11),
		.in_x(dx_s11), .in_y(dy_s11), .in_z('0), .in_side(dsd_s11),
		.out_valid(vd_c), .out_x(xd_c), .out_y(yd_c), .out_z(zd_c), .out_side(sdd_c)
	);

	srd_cordic #(.STEPS(CORDIC_STEPS), .AW(AW), .SW(2), .VECTORING(1'b1)) u_vec_ra (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s11),
		.in_x(rx_s11), .in_y(ry_s11), .in_z('0), .in_side(rsd_s11),
		.out_valid(ve_c), .out_x(xe_c), .out_y(ye_c), .out_z(ze_c), .out_side(sde_c)
	);

	// scale to degrees and hours
	localparam logic signed [AW:0] QUARTER = (AW + 1)'(1) <<< (AW - 2);
	logic signed [AW:0] adec_c, ara_c;
	logic signed [AW+9:0] dprod_c, dsh_c;
	logic [AW-1:0] rau_c;
	logic [AW+4:0] hprod_c, hsh_c;

	always_comb begin
		if (sdd_c[1])
			adec_c = sdd_c[0] ? -QUARTER : QUARTER;
		else
			adec_c = zd_c;
		if (sde_c[1])
			ara_c = sde_c[0] ? -QUARTER : QUARTER;
		else
			ara_c = ze_c;
		dprod_c = adec_c * $signed(10'sd360);
		dsh_c = dprod_c >>> (AW - 16);
		rau_c = {ara_c[AW-2:0], 1'b0};
		hprod_c = rau_c * 5'd24;
		hsh_c = hprod_c >> (AW - 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			pos_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= time_valid;
			v_s2 <= v_s1;
			v_s4 <= va_c & vb_c;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= vc_c;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= sq_vld_s[SQ_STEPS-1];
			pos_valid <= vd_c & ve_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mlo_s1 <= pml_c[63:0];
			mhi_s1 <= pmh_c[31:0];
			llo_s1 <= pll_c[63:0];
			lhi_s1 <= plh_c[31:0];

			ma_s2 <= m64_c[63 -: AW];
			lin_s2 <= lin_c;

			sm_s4 <= sda_c[SWA-1] ? -ya_c : ya_c;
			s2m_s4 <= sdb_c[0] ? -yb_c : yb_c;
			lin_s4 <= sda_c[AW +: 64];
			ma_s4 <= sda_c[AW-1:0];

			k1_s5 <= k1_c[63:0];
			k2_s5 <= k2_c[63:0];
			lin_s5 <= lin_s4;
			ma_s5 <= ma_s4;

			la_s6 <= l64_c[63 -: AW];

			cl_s7 <= sdc_c[0] ? -xc_c : xc_c;
			sl_s7 <= sdc_c[0] ? -yc_c : yc_c;

			yv_s8 <= yv_c[XW-1:0];
			zv_s8 <= zv_c[XW-1:0];
			cl_s8 <= cl_s7;

			zz_s9 <= zz_c[SQ_W-1:0];
			yv_s9 <= yv_s8;
			zv_s9 <= zv_s8;
			cl_s9 <= cl_s8;

			rem_s10 <= (zz_s9 > ONE_Q60) ? '0 : ONE_Q60 - zz_s9;
			yv_s10 <= yv_s9;
			zv_s10 <= zv_s9;
			cl_s10 <= cl_s9;

			dx_s11 <= rho_c;
			dy_s11 <= sq_zv_s[SQ_STEPS-1];
			dsd_s11 <= {rho_c <= 0, sq_zv_s[SQ_STEPS-1][XW-1]};
			rx_s11 <= (xr_c < 0) ? '0 : xr_c;
			ry_s11 <= sq_yv_s[SQ_STEPS-1];
			rsd_s11 <= {xr_c <= 0, sq_yv_s[SQ_STEPS-1][XW-1]};

			right_ascension <= hsh_c[20:0];
			declination <= dsh_c[21:0];
		end
	end

	`SRD_ASSERT_NOW(a_ra_range, pos_valid, right_ascension < 21'd1572864, "right ascension past 24 h")
	`SRD_ASSERT_NOW(a_dec_range, pos_valid, (declination <= 22'sd1572864) && (declination >= -22'sd1572864), "declination out of range")
	`SRD_ASSERT_NEXT(a_hold, pos_valid && !pos_ready, pos_valid && $stable(declination) && $stable(v_s11), "pipeline moved while stalled")

endmodule
